>>> rtl/core/mect_pkg.sv
package mect_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int KEY_BITS_DEF      = 64;

    localparam int CNT_BITS = 15;
    localparam int SUM_BITS = CNT_BITS + 2;
    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [CNT_BITS-1:0] THRESHOLD_RESET = 15'd255;

    localparam int CFG_DATA_BITS  = 15;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ERROR_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VERBOSE_ENABLE  = 1'b1;

    localparam logic [1:0] OUTCOME_IGNORED = 2'd0;
    localparam logic [1:0] OUTCOME_NEW     = 2'd1;
    localparam logic [1:0] OUTCOME_COUNTED = 2'd2;
    localparam logic [1:0] OUTCOME_FULL    = 2'd3;

    localparam logic [1:0] ADVICE_NONE    = 2'd0;
    localparam logic [1:0] ADVICE_VERBOSE = 2'd1;
    localparam logic [1:0] ADVICE_REPLACE = 2'd2;

    typedef struct packed {
        logic        name_present;
        logic [63:0] module_key;
        logic        error_sticky;
        logic        error_persistent;
    } request_t;

    typedef struct packed {
        logic [1:0]          outcome;
        logic [3:0]          entry_index;
        logic [CNT_BITS-1:0] intermittent_total;
        logic [CNT_BITS-1:0] persistent_total;
        logic [CNT_BITS-1:0] sticky_total;
        logic                limit_exceeded;
        logic [1:0]          advice;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ALLOC,
        ST_INCR,
        ST_CHECK
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_next;
        logic alloc;
        logic incr;
        logic check;
        logic emit_ignored;
        logic emit_full;
    } ctrl_cmd_t;

    typedef struct packed {
        logic name_present;
        logic table_empty;
        logic table_full;
        logic hit;
        logic scan_last;
    } dp_status_t;

    function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + 15'd1;
    endfunction

endpackage

>>> rtl/core/memory_module_error_counter_table_top.sv
// An item without a module name gives its result in the next cycle. A named
// item scans the table from slot 0: a hit passes through the increment and check
// states, a miss allocates a new entry (at once if the table is empty) and a full
// table ends the scan with a full result. busy drops as the result appears; an
// item without a name never raises busy. The result strobe cannot be stalled.
// Reset clears the fill count and verbose state, loads config defaults; no clearing pass.
module memory_module_error_counter_table_top #(
    parameter int TABLE_ENTRIES = mect_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = mect_pkg::KEY_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  mect_pkg::request_t                  request,
    output logic                                done,
    output mect_pkg::result_t                   result,
    input  logic                                cfg_write,
    input  logic [mect_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mect_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    mect_pkg::ctrl_cmd_t  cmd;
    mect_pkg::dp_status_t status;

    mect_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    mect_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result),
        .done      (done)
    );

    a_ignored_next: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !request.name_present
        |=> done && result.outcome == mect_pkg::OUTCOME_IGNORED)
        else $error("ignored item did not complete in one cycle");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.outcome == mect_pkg::OUTCOME_IGNORED
                 || result.outcome == mect_pkg::OUTCOME_FULL)
        |-> result.entry_index == '0 && !result.limit_exceeded
            && result.advice == mect_pkg::ADVICE_NONE
            && result.intermittent_total == '0 && result.persistent_total == '0
            && result.sticky_total == '0)
        else $error("ignored or full result carries nonzero fields");

    a_limit_on_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.limit_exceeded || result.advice != mect_pkg::ADVICE_NONE)
        |-> result.outcome == mect_pkg::OUTCOME_COUNTED)
        else $error("limit report on an item that did not count an entry");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.scan_next, cmd.alloc, cmd.incr, cmd.check, cmd.emit_full}))
        else $error("controller issued conflicting commands");

endmodule

>>> rtl/core/mect_ram.sv
module mect_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/core/mect_ctrl.sv
module mect_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mect_pkg::dp_status_t status,
    output mect_pkg::ctrl_cmd_t  cmd,
    output logic                busy
);

    mect_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mect_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mect_pkg::ST_IDLE:
            begin
                if (start && status.name_present)
                begin
                    state_next = status.table_empty ? mect_pkg::ST_ALLOC : mect_pkg::ST_SCAN;
                end
            end
            mect_pkg::ST_SCAN:
            begin
                if (status.hit)
                begin
                    state_next = mect_pkg::ST_INCR;
                end
                else if (status.scan_last)
                begin
                    state_next = status.table_full ? mect_pkg::ST_IDLE : mect_pkg::ST_ALLOC;
                end
            end
            mect_pkg::ST_ALLOC: state_next = mect_pkg::ST_IDLE;
            mect_pkg::ST_INCR:  state_next = mect_pkg::ST_CHECK;
            mect_pkg::ST_CHECK: state_next = mect_pkg::ST_IDLE;
            default:            state_next = mect_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            mect_pkg::ST_IDLE:
            begin
                busy             = 1'b0;
                cmd.load         = start;
                cmd.emit_ignored = start && !status.name_present;
            end
            mect_pkg::ST_SCAN:
            begin
                cmd.scan_next = !status.hit && !status.scan_last;
                cmd.emit_full = !status.hit && status.scan_last && status.table_full;
            end
            mect_pkg::ST_ALLOC: cmd.alloc = 1'b1;
            mect_pkg::ST_INCR:  cmd.incr  = 1'b1;
            mect_pkg::ST_CHECK: cmd.check = 1'b1;
            default:            busy      = 1'b1;
        endcase
    end

endmodule

>>> rtl/core/mect_dp.sv
module mect_dp #(
    parameter int TABLE_ENTRIES = mect_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = mect_pkg::KEY_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mect_pkg::request_t                     request,
    input  logic                                   cfg_write,
    input  logic [mect_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [mect_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  mect_pkg::ctrl_cmd_t                    cmd,
    output mect_pkg::dp_status_t                   status,
    output mect_pkg::result_t                      result,
    output logic                                   done
);

    localparam int CB    = mect_pkg::CNT_BITS;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int RAM_W = KEY_BITS + 3 * CB;

    logic [CB-1:0]       threshold_reg;
    logic                verbose_enable_reg;
    logic                verbose_on_reg, verbose_on_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [KEY_BITS-1:0] key_reg;
    logic                sticky_reg, persist_reg;
    logic [CB-1:0]       int_reg, int_next;
    logic [CB-1:0]       per_reg, per_next;
    logic [CB-1:0]       stk_reg, stk_next;
    mect_pkg::result_t   result_reg, result_next;
    logic                done_reg, done_next;

    logic                ram_we;
    logic [RAM_W-1:0]    ram_wdata, ram_rdata;
    logic [KEY_BITS-1:0] rd_key;
    logic [CB-1:0]       rd_int, rd_per, rd_stk;
    logic [CB-1:0]       new_int, new_per, new_stk;
    logic [mect_pkg::SUM_BITS-1:0] sum;
    logic                exceed;
    logic [1:0]          advice;

    assign {rd_key, rd_int, rd_per, rd_stk} = ram_rdata;

    mect_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (idx_next),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // The RAM is addressed with the next index, so the entry at idx_reg is on
    // the read port during the cycle that idx_reg holds it.
    always_comb
    begin
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.scan_next)
        begin
            idx_next = idx_reg + 1'b1;
        end
        else if (cmd.alloc)
        begin
            idx_next = fill_reg[IDX_W-1:0];
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    assign status.name_present = request.name_present;
    assign status.table_empty  = (fill_reg == '0);
    assign status.table_full   = (fill_reg == CNT_W'(TABLE_ENTRIES));
    assign status.hit          = (rd_key == key_reg);
    assign status.scan_last    = ((CNT_W'(idx_reg) + 1'b1) == fill_reg);

    // Counts for a freshly allocated entry: sticky wins over persistent.
    assign new_stk = CB'(sticky_reg);
    assign new_per = CB'(!sticky_reg && persist_reg);
    assign new_int = CB'(!sticky_reg && !persist_reg);

    assign sum    = mect_pkg::SUM_BITS'(int_reg) + mect_pkg::SUM_BITS'(per_reg)
                  + mect_pkg::SUM_BITS'(stk_reg);
    assign exceed = (sum > mect_pkg::SUM_BITS'(threshold_reg));

    always_comb
    begin
        if (!exceed)
        begin
            advice = mect_pkg::ADVICE_NONE;
        end
        else if (!verbose_enable_reg)
        begin
            advice = mect_pkg::ADVICE_REPLACE;
        end
        else if (!verbose_on_reg)
        begin
            advice = mect_pkg::ADVICE_VERBOSE;
        end
        else
        begin
            advice = mect_pkg::ADVICE_NONE;
        end
    end

    always_comb
    begin
        int_next        = int_reg;
        per_next        = per_reg;
        stk_next        = stk_reg;
        fill_next       = fill_reg;
        verbose_on_next = verbose_on_reg;
        result_next     = result_reg;
        done_next       = 1'b0;
        ram_we          = 1'b0;
        ram_wdata       = {key_reg, int_reg, per_reg, stk_reg};

        if (cmd.emit_ignored || cmd.emit_full)
        begin
            result_next         = '0;
            result_next.outcome = cmd.emit_full ? mect_pkg::OUTCOME_FULL
                                                : mect_pkg::OUTCOME_IGNORED;
            done_next           = 1'b1;
        end

        if (cmd.alloc)
        begin
            ram_we                         = 1'b1;
            ram_wdata                      = {key_reg, new_int, new_per, new_stk};
            fill_next                      = fill_reg + 1'b1;
            result_next.outcome            = mect_pkg::OUTCOME_NEW;
            result_next.entry_index        = 4'(idx_next);
            result_next.intermittent_total = new_int;
            result_next.persistent_total   = new_per;
            result_next.sticky_total       = new_stk;
            result_next.limit_exceeded     = 1'b0;
            result_next.advice             = mect_pkg::ADVICE_NONE;
            done_next                      = 1'b1;
        end

        if (cmd.incr)
        begin
            int_next = rd_int;
            per_next = rd_per;
            stk_next = rd_stk;
            if (sticky_reg)
            begin
                stk_next = mect_pkg::sat_inc(rd_stk);
            end
            else if (persist_reg)
            begin
                per_next = mect_pkg::sat_inc(rd_per);
            end
            else
            begin
                int_next = mect_pkg::sat_inc(rd_int);
            end
        end

        if (cmd.check)
        begin
            ram_we                         = 1'b1;
            ram_wdata                      = exceed ? {key_reg, {(3 * CB){1'b0}}}
                                                    : {key_reg, int_reg, per_reg, stk_reg};
            result_next.outcome            = mect_pkg::OUTCOME_COUNTED;
            result_next.entry_index        = 4'(idx_reg);
            result_next.intermittent_total = int_reg;
            result_next.persistent_total   = per_reg;
            result_next.sticky_total       = stk_reg;
            result_next.limit_exceeded     = exceed;
            result_next.advice             = advice;
            done_next                      = 1'b1;
            if (advice == mect_pkg::ADVICE_VERBOSE)
            begin
                verbose_on_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg      <= mect_pkg::THRESHOLD_RESET;
            verbose_enable_reg <= 1'b0;
            verbose_on_reg     <= 1'b0;
            fill_reg           <= '0;
            done_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    mect_pkg::CFG_ERROR_THRESHOLD: threshold_reg <= cfg_data;
                    mect_pkg::CFG_VERBOSE_ENABLE:  verbose_enable_reg <= cfg_data[0];
                    default:                       threshold_reg <= threshold_reg;
                endcase
            end
            verbose_on_reg <= verbose_on_next;
            fill_reg       <= fill_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg     <= request.module_key[KEY_BITS-1:0];
            sticky_reg  <= request.error_sticky;
            persist_reg <= request.error_persistent;
        end
        idx_reg    <= idx_next;
        int_reg    <= int_next;
        per_reg    <= per_next;
        stk_reg    <= stk_next;
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule
